// File: rtl/qvd_pkg.sv
// Shared types, character codes and helpers for the query value decoder.
package qvd_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_KEY,
        MODE_SKIP,
        MODE_VALUE,
        MODE_FOUND,
        MODE_ERROR
    } mode_t;

    // Characters with a meaning in a query string
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Final status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_ESC   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_TEXT   = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_OUT_LIMIT  = 2'd2;

    localparam int          LIMIT_W         = 13;
    localparam logic [12:0] OUT_LIMIT_RESET = 13'd64;

    // Results caused by one input word: up to two data bytes, then maybe a status
    typedef struct packed {
        logic [1:0] data_cnt;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       has_status;
        logic [1:0] status;
    } rec_t;

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 5'(c - 8'h57);
        else
            v = 5'h10;
        return v;
    endfunction

    // Plain value character: '+' stands for a space
    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

// File: rtl/qvd_front.sv
// Front end: takes one query byte per cycle while the queue is not full, tracks key match
// and escapes, and pushes the results of each byte, if any, as one record into the queue.
module qvd_front #(
    parameter int KEY_BYTES     = 8,
    parameter int MAX_VALUE_LEN = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic [KEY_BYTES*8-1:0]      key_text,
    input  logic [3:0]                  key_length,
    input  logic [qvd_pkg::LIMIT_W-1:0] out_limit,
    input  logic                        full,
    output logic                        push,
    output qvd_pkg::rec_t               rec
);

    localparam int CW = $clog2(MAX_VALUE_LEN);
    localparam int LW = (CW + 1 > qvd_pkg::LIMIT_W) ? CW + 1 : qvd_pkg::LIMIT_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_VALUE_LEN);

    qvd_pkg::mode_t mode_reg, mode_next;
    logic [3:0]     pos_reg, pos_next;
    logic           eq_reg, eq_next;
    logic [1:0]     pend_reg, pend_next;
    logic [7:0]     digit_reg;
    logic           digit_we;
    logic [CW-1:0]  written_reg, written_next;

    logic          fire;
    logic [LW-1:0] limit;
    logic [LW-1:0] wr_ext;
    logic          room_now, room1;
    logic          key_byte_ok, key_in_range, key_match;
    logic [4:0]    hi_nib, lo_nib;
    logic          hex_bad;
    logic [7:0]    hex_byte;

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;

    // Effective limit and room checks
    assign limit    = (LW'(out_limit) > MAX_L) ? MAX_L : LW'(out_limit);
    assign wr_ext   = LW'(written_reg);
    assign room_now = (wr_ext + LW'(1)) < limit;
    assign room1    = (wr_ext + LW'(2)) < limit;

    // Key byte compare at the current position
    always_comb
    begin
        key_byte_ok = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (pos_reg == 4'(i))
                key_byte_ok = (key_text[8*i +: 8] == in_byte);
        end
    end

    assign key_in_range = (pos_reg < key_length) && (pos_reg < 4'(KEY_BYTES));
    assign key_match    = eq_reg && (pos_reg == key_length) &&
                          (key_length <= 4'(KEY_BYTES));

    // Escape decode
    assign hi_nib   = qvd_pkg::hex_nib(digit_reg);
    assign lo_nib   = qvd_pkg::hex_nib(in_byte);
    assign hex_bad  = hi_nib[4] || lo_nib[4];
    assign hex_byte = {hi_nib[3:0], lo_nib[3:0]};

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            qvd_pkg::MODE_KEY:
            begin
                if (in_byte == qvd_pkg::CH_EQ)
                begin
                    if (key_match)
                        mode_next = room_now ? qvd_pkg::MODE_VALUE : qvd_pkg::MODE_FOUND;
                    else
                        mode_next = qvd_pkg::MODE_SKIP;
                end
            end
            qvd_pkg::MODE_SKIP:
            begin
                if (in_byte == qvd_pkg::CH_NUL || in_byte == qvd_pkg::CH_AMP)
                    mode_next = qvd_pkg::MODE_KEY;
            end
            qvd_pkg::MODE_VALUE:
            begin
                if (in_byte == qvd_pkg::CH_NUL)
                    mode_next = qvd_pkg::MODE_KEY;
                else if (in_byte == qvd_pkg::CH_AMP)
                    mode_next = qvd_pkg::MODE_FOUND;
                else if (pend_reg == 2'd0)
                begin
                    if (in_byte != qvd_pkg::CH_PCT && !room1)
                        mode_next = qvd_pkg::MODE_FOUND;
                end
                else if (pend_reg == 2'd2)
                begin
                    if (hex_bad)
                        mode_next = qvd_pkg::MODE_ERROR;
                    else if (!room1)
                        mode_next = qvd_pkg::MODE_FOUND;
                end
            end
            qvd_pkg::MODE_FOUND, qvd_pkg::MODE_ERROR:
            begin
                if (in_byte == qvd_pkg::CH_NUL)
                    mode_next = qvd_pkg::MODE_KEY;
            end
            default: mode_next = qvd_pkg::MODE_KEY;
        endcase
    end

    // Results and datapath next values
    always_comb
    begin
        rec          = '0;
        pos_next     = pos_reg;
        eq_next      = eq_reg;
        pend_next    = pend_reg;
        digit_we     = 1'b0;
        written_next = written_reg;
        unique case (mode_reg)
            qvd_pkg::MODE_KEY:
            begin
                if (in_byte == qvd_pkg::CH_NUL)
                begin
                    rec.has_status = 1'b1;
                    rec.status     = qvd_pkg::ST_NOT_FOUND;
                    pos_next       = '0;
                    eq_next        = 1'b1;
                end
                else if (in_byte == qvd_pkg::CH_AMP)
                begin
                    pos_next = '0;
                    eq_next  = 1'b1;
                end
                else if (in_byte == qvd_pkg::CH_EQ)
                begin
                    pend_next = '0;
                end
                else
                begin
                    if (!key_in_range || !key_byte_ok)
                        eq_next = 1'b0;
                    if (pos_reg != 4'd15)
                        pos_next = pos_reg + 4'd1;
                end
            end
            qvd_pkg::MODE_SKIP:
            begin
                if (in_byte == qvd_pkg::CH_NUL)
                begin
                    rec.has_status = 1'b1;
                    rec.status     = qvd_pkg::ST_NOT_FOUND;
                end
                if (in_byte == qvd_pkg::CH_NUL || in_byte == qvd_pkg::CH_AMP)
                begin
                    pos_next = '0;
                    eq_next  = 1'b1;
                end
            end
            qvd_pkg::MODE_VALUE:
            begin
                if (in_byte == qvd_pkg::CH_NUL || in_byte == qvd_pkg::CH_AMP)
                begin
                    // flush a short escape literally
                    if (pend_reg != 2'd0)
                    begin
                        rec.data_cnt = 2'd1;
                        rec.byte0    = qvd_pkg::CH_PCT;
                        if (pend_reg == 2'd2 && room1)
                        begin
                            rec.data_cnt = 2'd2;
                            rec.byte1    = qvd_pkg::plain_map(digit_reg);
                        end
                    end
                    pend_next    = '0;
                    written_next = written_reg + CW'(rec.data_cnt);
                    if (in_byte == qvd_pkg::CH_NUL)
                    begin
                        rec.has_status = 1'b1;
                        rec.status     = qvd_pkg::ST_FOUND;
                        pos_next       = '0;
                        eq_next        = 1'b1;
                        written_next   = '0;
                    end
                end
                else if (pend_reg == 2'd0)
                begin
                    if (in_byte == qvd_pkg::CH_PCT)
                        pend_next = 2'd1;
                    else
                    begin
                        rec.data_cnt = 2'd1;
                        rec.byte0    = qvd_pkg::plain_map(in_byte);
                        written_next = written_reg + CW'(1);
                    end
                end
                else if (pend_reg == 2'd1)
                begin
                    digit_we  = 1'b1;
                    pend_next = 2'd2;
                end
                else
                begin
                    pend_next = '0;
                    if (!hex_bad)
                    begin
                        rec.data_cnt = 2'd1;
                        rec.byte0    = hex_byte;
                        written_next = written_reg + CW'(1);
                    end
                end
            end
            qvd_pkg::MODE_FOUND, qvd_pkg::MODE_ERROR:
            begin
                if (in_byte == qvd_pkg::CH_NUL)
                begin
                    rec.has_status = 1'b1;
                    rec.status     = (mode_reg == qvd_pkg::MODE_ERROR) ?
                                     qvd_pkg::ST_BAD_ESC : qvd_pkg::ST_FOUND;
                    pos_next       = '0;
                    eq_next        = 1'b1;
                    pend_next      = '0;
                    written_next   = '0;
                end
            end
            default:
            begin
                pos_next     = '0;
                eq_next      = 1'b1;
                pend_next    = '0;
                written_next = '0;
            end
        endcase
    end

    assign push = fire && (rec.data_cnt != 2'd0 || rec.has_status);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= qvd_pkg::MODE_KEY;
            pos_reg     <= '0;
            eq_reg      <= 1'b1;
            pend_reg    <= '0;
            written_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            eq_reg      <= eq_next;
            pend_reg    <= pend_next;
            written_reg <= written_next;
        end
    end

    // Held first escape digit
    always_ff @(posedge clk)
    begin
        if (fire && digit_we)
            digit_reg <= in_byte;
    end

    // An escape is only pending while decoding a value
    a_pend_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd0) |-> (mode_reg == qvd_pkg::MODE_VALUE))
        else $error("escape pending outside value mode");

    // Value mode always has room for one more byte
    a_value_room: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == qvd_pkg::MODE_VALUE) |-> room_now)
        else $error("value mode without output room");

endmodule

// File: rtl/qvd_fifo.sv
// Record queue between front and back end.
module qvd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qvd_pkg::rec_t wr_rec,
    input  logic          pop,
    output qvd_pkg::rec_t rd_rec,
    output logic          full,
    output logic          empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    qvd_pkg::rec_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    assign full   = (cnt_reg == NW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_rec = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + NW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

// File: rtl/qvd_back.sv
// Back end: walks the head record one result per cycle into the output register while it is free.
module qvd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  qvd_pkg::rec_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_is_status,
    output logic [1:0]    out_status,
    output logic          out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       is_status_reg;
    logic [1:0] status_reg;
    logic       last_reg;

    logic [1:0] total;
    logic       out_free, emit, item_last, item_data;
    logic [7:0] item_byte;

    assign total     = head.data_cnt + 2'(head.has_status);
    assign out_free  = !valid_reg || out_ready;
    assign emit      = head_valid && out_free;
    assign item_data = idx_reg < head.data_cnt;
    assign item_last = (idx_reg == total - 2'd1);
    assign item_byte = (idx_reg == 2'd0) ? head.byte0 : head.byte1;
    assign pop       = emit && item_last;

    // Result index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            idx_next   = item_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg      <= item_data ? item_byte : 8'd0;
            is_status_reg <= !item_data;
            status_reg    <= item_data ? qvd_pkg::ST_FOUND : head.status;
            last_reg      <= item_last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_is_status = is_status_reg;
    assign out_status    = status_reg;
    assign out_last      = last_reg;

    a_idx_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < total))
        else $error("result index past end of record");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == 2'd0))
        else $error("result index left over with empty queue");

endmodule

// File: rtl/query_value_extract_url_decode.sv
// Flow: one input word per cycle while the record queue is not full; the back end sends
// one result word per cycle while m_tready takes them, so a word with two or three results
// holds the output for each of them in turn, and the record queue (FIFO_DEPTH records)
// lets input continue meanwhile until it fills.
// Reset: rst_n (async, active low) clears parser state and queue, sets key_text 0,
// key_length 0, out_limit 64.
module query_value_extract_url_decode #(
    parameter int KEY_BYTES     = 8,
    parameter int MAX_VALUE_LEN = 4096,
    parameter int FIFO_DEPTH    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_tuser,    // [0] is_status
    output logic        m_tlast,    // run_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [KEY_BYTES*8-1:0]      key_text_reg;
    logic [3:0]                  key_length_reg;
    logic [qvd_pkg::LIMIT_W-1:0] out_limit_reg;

    logic          push, pop, full, empty;
    qvd_pkg::rec_t wr_rec, rd_rec;
    logic [7:0]    out_byte;
    logic [1:0]    out_status;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= '0;
            key_length_reg <= '0;
            out_limit_reg  <= qvd_pkg::OUT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qvd_pkg::CFG_KEY_TEXT:   key_text_reg   <= cfg_data[KEY_BYTES*8-1:0];
                qvd_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                qvd_pkg::CFG_OUT_LIMIT:  out_limit_reg  <= cfg_data[qvd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    qvd_front #(
        .KEY_BYTES     (KEY_BYTES),
        .MAX_VALUE_LEN (MAX_VALUE_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .key_text   (key_text_reg),
        .key_length (key_length_reg),
        .out_limit  (out_limit_reg),
        .full       (full),
        .push       (push),
        .rec        (wr_rec)
    );

    qvd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (wr_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .full   (full),
        .empty  (empty)
    );

    qvd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (rd_rec),
        .head_valid    (!empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (out_byte),
        .out_is_status (m_tuser),
        .out_status    (out_status),
        .out_last      (m_tlast)
    );

    assign m_tdata = {6'd0, out_status, out_byte};

endmodule
